FILE: hdl/rhb_pkg.sv
package rhb_pkg;

	localparam int NBINS          = 64;
	localparam int LOG_TABLE_BITS = 8;
	localparam int LOG_TABLE_SIZE = 1 << LOG_TABLE_BITS;
	localparam int BIN_AW         = (NBINS > 1) ? $clog2(NBINS) : 1;
	localparam int CNT_W          = $clog2(NBINS + 1);

	localparam int FIX_W         = 32;
	localparam int FRAC_W        = 16;
	localparam int TOTAL_W       = 48;
	localparam int BIN_NUM_W     = 6;
	localparam int BIN_CNT_REG_W = 7;
	localparam int POS_W         = 5;
	localparam int EXP_W         = POS_W + 1;
	// signed offset domain: radius or log value minus signed origin
	localparam int DOM_W         = FIX_W + 2;
	localparam int PROD_W        = 2 * FIX_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [TOTAL_W-1:0]       TOTAL_MAX       = '1;
	localparam logic [FIX_W-1:0]         ONE_UNIT        = 32'h0001_0000;
	localparam logic [FIX_W-1:0]         SCALE_RESET     = 32'h0001_0000;
	localparam logic [BIN_CNT_REG_W-1:0] BIN_COUNT_RESET = 7'd64;
	localparam logic [EXP_W-1:0]         EXP_BIAS        = 6'd16;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOG_MODE   = 3'd0,
		REG_USE_WEIGHT = 3'd1,
		REG_BIN_ORIGIN = 3'd2,
		REG_BIN_SCALE  = 3'd3,
		REG_BIN_COUNT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NORM,
		S_OFFSET,
		S_MUL,
		S_INDEX,
		S_ADD_RD,
		S_ADD_WR,
		S_RD_RD,
		S_RD_OUT
	} rhb_state_t;

	typedef struct packed {
		logic capture;
		logic norm_step;
		logic calc_offset;
		logic calc_mul;
		logic calc_index;
		logic ram_rd_add;
		logic ram_wr_add;
		logic ram_rd_read;
		logic out_load;
	} rhb_cmd_t;

	typedef struct packed {
		logic in_is_read;
		logic norm_done;
		logic out_free;
	} rhb_stat_t;

	typedef logic [FRAC_W-1:0] frac_tab_t [LOG_TABLE_SIZE];

	// log2(1 + i/2^bits) by repeated squaring of a Q1.30 mantissa
	function automatic frac_tab_t build_frac_tab();
		frac_tab_t          t;
		logic [63:0]        m;
		logic [FRAC_W-1:0]  r;
		for (int i = 0; i < LOG_TABLE_SIZE; i++) begin
			m = (64'd1 << 30) | (64'(i) << (30 - LOG_TABLE_BITS));
			r = '0;
			for (int k = 0; k < FRAC_W; k++) begin
				m = (m * m) >> 30;
				r = {r[FRAC_W-2:0], 1'b0};
				if (m >= (64'd1 << 31)) begin
					r[0] = 1'b1;
					m = m >> 1;
				end
			end
			t[i] = r;
		end
		return t;
	endfunction

	localparam frac_tab_t LOG_FRAC = build_frac_tab();

endpackage

FILE: hdl/rhb_in_if.sv
interface rhb_in_if import rhb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [FIX_W-1:0]     radius;
	logic [FIX_W-1:0]     weight;
	logic [BIN_NUM_W-1:0] read_bin;

	modport source (output valid, command, radius, weight, read_bin, input ready);
	modport sink (input valid, command, radius, weight, read_bin, output ready);
endinterface

FILE: hdl/rhb_out_if.sv
interface rhb_out_if import rhb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [TOTAL_W-1:0]   bin_total;
	logic [BIN_NUM_W-1:0] bin_number;

	modport source (output valid, bin_total, bin_number, input ready);
	modport sink (input valid, bin_total, bin_number, output ready);
endinterface

FILE: hdl/rhb_cfg_if.sv
interface rhb_cfg_if import rhb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/rhb_ram.sv
module rhb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/rhb_ctrl.sv
module rhb_ctrl import rhb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rhb_stat_t stat,
	output rhb_cmd_t  cmd
);

	rhb_state_t state_q;
	rhb_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = stat.in_is_read ? S_RD_RD : S_NORM;
				end
			end
			S_NORM: begin
				// one bit of leading-one search per cycle
				if (stat.norm_done) begin
					state_d = S_OFFSET;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_OFFSET: begin
				cmd.calc_offset = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.calc_mul = 1'b1;
				state_d = S_INDEX;
			end
			S_INDEX: begin
				cmd.calc_index = 1'b1;
				state_d = S_ADD_RD;
			end
			S_ADD_RD: begin
				cmd.ram_rd_add = 1'b1;
				state_d = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.ram_wr_add = 1'b1;
				state_d = S_IDLE;
			end
			S_RD_RD: begin
				cmd.ram_rd_read = 1'b1;
				state_d = S_RD_OUT;
			end
			S_RD_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/rhb_dp.sv
module rhb_dp import rhb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rhb_cmd_t             cmd,
	output rhb_stat_t            stat,
	input  logic                 command,
	input  logic [FIX_W-1:0]     radius,
	input  logic [FIX_W-1:0]     weight,
	input  logic [BIN_NUM_W-1:0] read_bin,
	rhb_out_if.source            result,
	rhb_cfg_if.sink              cfg
);

	// configuration
	logic                     log_mode_q;
	logic                     use_weight_q;
	logic [FIX_W-1:0]         bin_origin_q;
	logic [FIX_W-1:0]         bin_scale_q;
	logic [BIN_CNT_REG_W-1:0] bin_count_q;

	// request fields
	logic [FIX_W-1:0]     radius_q;
	logic [FIX_W-1:0]     weight_q;
	logic [BIN_NUM_W-1:0] read_bin_q;
	logic                 rad_zero_q;
	logic                 in_range_q;

	// index datapath
	logic [FIX_W-1:0]  norm_q;
	logic [POS_W-1:0]  pos_q;
	logic [DOM_W-1:0]  offs_q;
	logic              offs_pos_q;
	logic [PROD_W-1:0] prod_q;
	logic              offs_hi_q;
	logic [BIN_AW-1:0] idx_q;

	// bin store
	logic [NBINS-1:0]   valid_q;
	logic               hit_q;
	logic               ram_we;
	logic               ram_re;
	logic [BIN_AW-1:0]  ram_raddr;
	logic [TOTAL_W-1:0] ram_wdata;
	logic [TOTAL_W-1:0] ram_rdata;
	logic [BIN_AW-1:0]  rd_addr;

	logic                 out_valid_q;
	logic [TOTAL_W-1:0]   out_total_q;
	logic [BIN_NUM_W-1:0] out_num_q;

	logic [LOG_TABLE_BITS-1:0] frac_idx;
	logic [FRAC_W-1:0]         frac;
	logic [EXP_W-1:0]          expo;
	logic [DOM_W-1:0]          dom_x;
	logic [DOM_W-1:0]          origin_x;
	logic [DOM_W-1:0]          offs;
	logic [DOM_W-1:0]          quot;
	logic [CNT_W-1:0]          cnt_eff;
	logic [CNT_W-1:0]          cnt_last;
	logic [TOTAL_W-1:0]        cur_total;
	logic [FIX_W-1:0]          add_amt;
	logic [TOTAL_W:0]          sum;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_mode_q   <= 1'b0;
			use_weight_q <= 1'b0;
			bin_origin_q <= '0;
			bin_scale_q  <= SCALE_RESET;
			bin_count_q  <= BIN_COUNT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOG_MODE:   log_mode_q   <= cfg.data[0];
				REG_USE_WEIGHT: use_weight_q <= cfg.data[0];
				REG_BIN_ORIGIN: bin_origin_q <= cfg.data[FIX_W-1:0];
				REG_BIN_SCALE:  bin_scale_q  <= cfg.data[FIX_W-1:0];
				REG_BIN_COUNT:  bin_count_q  <= cfg.data[BIN_CNT_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign stat.in_is_read = (command == CMD_READ);
	assign stat.norm_done  = !log_mode_q || rad_zero_q || norm_q[FIX_W-1] || (pos_q == '0);
	assign stat.out_free   = !out_valid_q || result.ready;

	// bits after the leading one, zero padded by the shifting
	assign frac_idx = norm_q[FIX_W-2 -: LOG_TABLE_BITS];
	assign frac     = LOG_FRAC[frac_idx];
	assign expo     = {1'b0, pos_q} - EXP_BIAS;
	assign dom_x    = log_mode_q ? {{(DOM_W-EXP_W-FRAC_W){expo[EXP_W-1]}}, expo, frac}
	                             : {{(DOM_W-FIX_W){1'b0}}, radius_q};
	assign origin_x = {{(DOM_W-FIX_W){bin_origin_q[FIX_W-1]}}, bin_origin_q};
	assign offs     = dom_x - origin_x;

	// upper offset bit contributes the whole scale
	assign quot = {{(DOM_W-FIX_W){1'b0}}, prod_q[PROD_W-1 -: FIX_W]}
	            + (offs_hi_q ? {{(DOM_W-FIX_W){1'b0}}, bin_scale_q} : '0);

	always_comb begin
		if (bin_count_q == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (32'(bin_count_q) > 32'(NBINS)) begin
			cnt_eff = CNT_W'(NBINS);
		end else begin
			cnt_eff = CNT_W'(bin_count_q);
		end
	end
	assign cnt_last = cnt_eff - CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			radius_q   <= radius;
			weight_q   <= weight;
			read_bin_q <= read_bin;
			rad_zero_q <= (radius == '0);
			in_range_q <= (32'(read_bin) < 32'(NBINS));
			norm_q     <= radius;
			pos_q      <= '1;
		end else if (cmd.norm_step) begin
			norm_q <= {norm_q[FIX_W-2:0], 1'b0};
			pos_q  <= pos_q - POS_W'(1);
		end
		if (cmd.calc_offset) begin
			offs_q     <= offs;
			offs_pos_q <= !offs[DOM_W-1] && (offs != '0) && !(log_mode_q && rad_zero_q);
		end
		if (cmd.calc_mul) begin
			prod_q    <= PROD_W'(offs_q[FIX_W-1:0]) * PROD_W'(bin_scale_q);
			offs_hi_q <= offs_q[FIX_W];
		end
		if (cmd.calc_index) begin
			if (!offs_pos_q) begin
				idx_q <= '0;
			end else if (quot >= DOM_W'(cnt_eff)) begin
				idx_q <= BIN_AW'(cnt_last);
			end else begin
				idx_q <= BIN_AW'(quot);
			end
		end
	end

	assign rd_addr   = BIN_AW'(read_bin_q);
	assign ram_re    = cmd.ram_rd_add || cmd.ram_rd_read;
	assign ram_raddr = cmd.ram_rd_add ? idx_q : rd_addr;
	assign ram_we    = cmd.ram_wr_add;

	// entries never written since reset or since read read as zero
	assign cur_total = hit_q ? ram_rdata : '0;
	assign add_amt   = use_weight_q ? weight_q : ONE_UNIT;
	assign sum       = {1'b0, cur_total} + (TOTAL_W+1)'(add_amt);
	assign ram_wdata = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

	rhb_ram #(
		.WIDTH(TOTAL_W),
		.DEPTH(NBINS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ram_re) begin
			hit_q <= valid_q[ram_raddr];
		end
		if (cmd.out_load) begin
			out_total_q <= (hit_q && in_range_q) ? ram_rdata : '0;
			out_num_q   <= read_bin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (cmd.out_load && in_range_q) begin
				valid_q[rd_addr] <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.bin_total  = out_total_q;
	assign result.bin_number = out_num_q;

endmodule

FILE: hdl/radial_histogram_binner_unit.sv
// channel    role   handshake        payload
// particle   sink   valid / ready    command, radius, weight, read_bin
// result     src    valid / ready    bin_total, bin_number
// cfg        sink   valid / ready    index, data (ready always high)
//
// an add request runs norm, offset, multiply, index, bin read and bin write; the norm step
// shifts nothing in linear mode, and in log mode the leading-one search shifts one bit a cycle
// a read request does a bin store read with registered data, then output load
// the bin store is a single-port-write ram with one valid flop per bin, cleared at reset
// a finished read waits in the output register while the next request is taken; a
// second read stalls in its last cycle until that register is free
module radial_histogram_binner_unit import rhb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rhb_in_if.sink    particle,
	rhb_out_if.source result,
	rhb_cfg_if.sink   cfg
);

	rhb_cmd_t  cmd;
	rhb_stat_t stat;

	rhb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(particle.valid),
		.in_ready(particle.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	rhb_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.command (particle.command),
		.radius  (particle.radius),
		.weight  (particle.weight),
		.read_bin(particle.read_bin),
		.result  (result),
		.cfg     (cfg)
	);

endmodule
